[rtl/core/ihbw_pkg.sv]
// shared constants, types and state encoding for the bin width block
package ihbw_pkg;
    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 30;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W         = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int D_W           = 31;
    localparam int LIMB_W        = 32;
    localparam int LIMBS         = 4;
    localparam int WIDE_W        = LIMB_W * LIMBS;
    localparam int LIMB_IDX_W    = $clog2(LIMBS);
    localparam int PASS_W        = 2;
    localparam int CUBE_PASSES   = 2;
    localparam int SEARCH_PASSES = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // per cell content handed down the chain
    typedef struct packed {
        logic    valid;
        sample_t value;
    } cell_data_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SHIFT,
        ST_GRAB,
        ST_MEDIAN,
        ST_CUBE,
        ST_SEARCH,
        ST_MUL,
        ST_CHECK,
        ST_DONE
    } state_t;
endpackage

[rtl/core/ihbw_cell.sv]
// one sorting cell: keeps the smaller value, passes the larger one down
module ihbw_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 shift,
    input  ihbw_pkg::cell_data_t in_data,
    output ihbw_pkg::cell_data_t held,
    output ihbw_pkg::cell_data_t pass_out
);
    ihbw_pkg::cell_data_t held_reg, held_next, pass_reg, pass_next;
    assign held     = held_reg;
    assign pass_out = pass_reg;

    // insertion compare, or plain shift during readout
    always_comb
    begin
        held_next = held_reg;
        pass_next = '0;
        if (shift)
        begin
            held_next = in_data;
            pass_next = held_reg;
        end
        else if (in_data.valid)
        begin
            if (!held_reg.valid || in_data.value < held_reg.value)
            begin
                held_next = in_data;
                pass_next = held_reg;
            end
            else
            begin
                pass_next = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pass_reg <= '0;
        end
        else if (clear)
        begin
            held_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end
endmodule

[rtl/core/ihbw_chain.sv]
// row of sorting cells; shift mode drains smallest first at the head
module ihbw_chain
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 shift,
    input  ihbw_pkg::cell_data_t in_data,
    output ihbw_pkg::cell_data_t head
);
    localparam int N = ihbw_pkg::MAX_SAMPLES;
    ihbw_pkg::cell_data_t link [N+1];
    ihbw_pkg::cell_data_t held [N];
    ihbw_pkg::cell_data_t feed [N];

    assign head = held[0];

    // insert from the head, drain toward the head
    genvar g;
    for (g = 0; g < N; g++)
    begin : g_cell
        if (g == N - 1)
        begin : g_tail
            assign feed[g] = shift ? '0 : link[g];
        end
        else
        begin : g_mid
            assign feed[g] = shift ? held[g+1] : link[g];
        end
        ihbw_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear),
            .shift    (shift),
            .in_data  (feed[g]),
            .held     (held[g]),
            .pass_out (link[g+1])
        );
    end
    assign link[0] = in_data;
endmodule

[rtl/core/integer_histogram_bin_width.sv]
// top level: sorting chain, quartile pickup and cube-root search
// Usage: samples stream in on sample/last with in_valid/in_stall, one beat
// per cycle while loading. Each sample is inserted into a row of sorting
// cells, one cell per stored sample; a new sample may follow every cycle.
// Samples past MAX_SAMPLES are dropped and reported on overflowed.
// After the beat marked last the block stalls its input while the chain
// settles and drains head first so the quartile elements are picked up.
// It then forms d = 2*(Q3-Q1) and cubes it; a binary search over r in [0,d]
// follows with one 32x32 multiply per cycle over four limbs: each step picks
// mid, forms r*r, r*r*r and times n, then compares, for at most 31 steps.
// Once the result is posted the block passes through its done state and
// then reopens its input.
// The result beat sits in an output register on out_valid until out_stall
// is low; the next column may load meanwhile, and if its result is ready
// first the search holds and the input stays stalled until the beat is taken.
// Reset clears the chain, the count and the dropped flag.
module integer_histogram_bin_width
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [29:0] sample,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] bin_width,
    output logic        overflowed
);
    localparam int CW  = ihbw_pkg::CNT_W;
    localparam int DW  = ihbw_pkg::D_W;
    localparam int LW  = ihbw_pkg::LIMB_W;
    localparam int WW  = ihbw_pkg::WIDE_W;
    localparam int PRW = 2 * ihbw_pkg::LIMB_W;
    localparam int LIW = ihbw_pkg::LIMB_IDX_W;
    localparam int PSW = ihbw_pkg::PASS_W;

    ihbw_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] wait_reg, wait_next;
    logic [LIW-1:0] limb_reg, limb_next;
    logic [PSW-1:0] pass_reg, pass_next;
    ihbw_pkg::sample_t a1_reg, a1_next, b1_reg, b1_next;
    ihbw_pkg::sample_t a3_reg, a3_next, b3_reg, b3_next;
    logic [DW-1:0] d_reg, d_next, lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [WW-1:0] dc_reg, dc_next, acc_reg, acc_next;
    logic [LW-1:0] carry_reg, carry_next;
    logic          ov_reg, ov_next, valid_reg, valid_next;
    logic [DW-1:0] bw_reg, bw_next;

    logic accept, store;
    ihbw_pkg::cell_data_t ins, head;
    logic [CW-1:0] i1a, i1b, i3a, i3b, half;
    logic [DW:0]   med1, med3;
    logic [DW-1:0] mid_calc;
    logic [LW-1:0] factor;
    logic [PRW-1:0] prod;
    logic [WW-1:0] rot;
    logic          limb_end;

    assign accept = in_valid && !in_stall;
    assign store  = accept && (count_reg < CW'(ihbw_pkg::MAX_SAMPLES));
    assign ins.valid = store;
    assign ins.value = sample[ihbw_pkg::SAMPLE_BITS-1:0];
    assign in_stall  = (state_reg != ihbw_pkg::ST_LOAD);
    assign out_valid = valid_reg;
    assign bin_width = bw_reg;
    assign overflowed = ov_reg;

    ihbw_chain u_chain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (state_reg == ihbw_pkg::ST_DONE),
        .shift   (state_reg == ihbw_pkg::ST_GRAB),
        .in_data (ins),
        .head    (head)
    );

    // quartile element positions in sorted order
    always_comb
    begin
        half = count_reg >> 1;
        if (count_reg[0])
        begin
            // lower run 0..half, length half+1
            i1a = ((half + 1'b1) >> 1);
            i1b = ((half + 1'b1) & 1) != 0 ? i1a : i1a - 1'b1;
            i3a = half + ((half + 1'b1) >> 1);
            i3b = ((half + 1'b1) & 1) != 0 ? i3a : i3a - 1'b1;
        end
        else
        begin
            i1a = half >> 1;
            i1b = half[0] ? i1a : i1a - 1'b1;
            i3a = half + (half >> 1);
            i3b = half[0] ? i3a : i3a - 1'b1;
        end
        med1 = ({1'b0, a1_reg} + {1'b0, b1_reg}) >> 1;
        med3 = ({1'b0, a3_reg} + {1'b0, b3_reg}) >> 1;
    end

    // one limb of the wide multiply per cycle, rotating the accumulator
    always_comb
    begin
        mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
        if (state_reg == ihbw_pkg::ST_CUBE)
            factor = LW'(d_reg);
        else if (pass_reg == PSW'(ihbw_pkg::SEARCH_PASSES - 1))
            factor = LW'(count_reg);
        else
            factor = LW'(mid_reg);
        prod = PRW'(acc_reg[LW-1:0]) * PRW'(factor) + PRW'(carry_reg);
        rot  = {prod[LW-1:0], acc_reg[WW-1:LW]};
        limb_end = (limb_reg == LIW'(ihbw_pkg::LIMBS - 1));
    end

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        limb_next  = limb_reg;
        pass_next  = pass_reg;
        a1_next = a1_reg; b1_next = b1_reg; a3_next = a3_reg; b3_next = b3_reg;
        d_next = d_reg; lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        dc_next = dc_reg; acc_next = acc_reg; carry_next = carry_reg;
        ov_next = ov_reg; bw_next = bw_reg;
        valid_next = valid_reg && out_stall;
        case (state_reg)
            ihbw_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (store) count_next = count_reg + 1'b1;
                    else drop_next = 1'b1;
                    if (last)
                    begin
                        state_next = ihbw_pkg::ST_SHIFT;
                        wait_next  = '0;
                    end
                end
            end
            ihbw_pkg::ST_SHIFT:
            begin
                wait_next = wait_reg + 1'b1;
                idx_next  = '0;
                if (wait_reg == CW'(ihbw_pkg::MAX_SAMPLES))
                    state_next = ihbw_pkg::ST_GRAB;
            end
            ihbw_pkg::ST_GRAB:
            begin
                if (idx_reg == i1a) a1_next = head.value;
                if (idx_reg == i1b) b1_next = head.value;
                if (idx_reg == i3a) a3_next = head.value;
                if (idx_reg == i3b) b3_next = head.value;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1) state_next = ihbw_pkg::ST_MEDIAN;
            end
            ihbw_pkg::ST_MEDIAN:
            begin
                d_next = DW'((med3 - med1) << 1);
                mid_next = '0;
                acc_next = WW'(d_next);
                carry_next = '0;
                limb_next = '0;
                pass_next = '0;
                state_next = ihbw_pkg::ST_CUBE;
            end
            ihbw_pkg::ST_CUBE:
            begin
                acc_next = rot;
                carry_next = prod[PRW-1:LW];
                limb_next = limb_reg + 1'b1;
                if (limb_end)
                begin
                    carry_next = '0;
                    limb_next = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == PSW'(ihbw_pkg::CUBE_PASSES - 1))
                    begin
                        dc_next = rot;
                        lo_next = '0;
                        hi_next = d_reg;
                        state_next = ihbw_pkg::ST_SEARCH;
                    end
                end
            end
            ihbw_pkg::ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_calc;
                    acc_next = WW'(mid_calc);
                    carry_next = '0;
                    limb_next = '0;
                    pass_next = '0;
                    state_next = ihbw_pkg::ST_MUL;
                end
                else if (!(valid_reg && out_stall))
                begin
                    // post only once the previous beat is gone
                    bw_next = (lo_reg == '0) ? DW'(1) : lo_reg;
                    ov_next = drop_reg;
                    valid_next = 1'b1;
                    state_next = ihbw_pkg::ST_DONE;
                end
            end
            ihbw_pkg::ST_MUL:
            begin
                acc_next = rot;
                carry_next = prod[PRW-1:LW];
                limb_next = limb_reg + 1'b1;
                if (limb_end)
                begin
                    carry_next = '0;
                    limb_next = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == PSW'(ihbw_pkg::SEARCH_PASSES - 1))
                        state_next = ihbw_pkg::ST_CHECK;
                end
            end
            ihbw_pkg::ST_CHECK:
            begin
                if (acc_reg >= dc_reg) hi_next = mid_reg;
                else lo_next = mid_reg + 1'b1;
                state_next = ihbw_pkg::ST_SEARCH;
            end
            ihbw_pkg::ST_DONE:
            begin
                count_next = '0;
                drop_next  = 1'b0;
                state_next = ihbw_pkg::ST_LOAD;
            end
            default: state_next = ihbw_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ihbw_pkg::ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            wait_reg  <= '0;
            limb_reg  <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            wait_reg  <= wait_next;
            limb_reg  <= limb_next;
            pass_reg  <= pass_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a1_reg <= a1_next; b1_reg <= b1_next; a3_reg <= a3_next; b3_reg <= b3_next;
        d_reg <= d_next; lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
        dc_reg <= dc_next; acc_reg <= acc_next; carry_reg <= carry_next;
        ov_reg <= ov_next; bw_reg <= bw_next;
    end
endmodule

[rtl/core/ihbw_checker.sv]
// port level checks for the bin width block, bound to the top level
module ihbw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] bin_width,
    input logic        overflowed
);
    // result beat holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_width) && $stable(overflowed))
        else $error("result beat changed under stall");
    // width is never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bin_width != 31'd0)
        else $error("zero bin width");
    // handshake outputs and a posted beat are always known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}) &&
        (!out_valid || !$isunknown({bin_width, overflowed})))
        else $error("unknown value on handshake or result beat");
endmodule

bind integer_histogram_bin_width ihbw_checker u_ihbw_checker
(
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .bin_width(bin_width),
    .overflowed(overflowed)
);

[sim/integer_histogram_bin_width_tb.sv]
// testbench for the histogram bin width block: columns of samples in, widths out
module integer_histogram_bin_width_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // expected width of one column, kept in arrival order
    typedef struct {
        logic [30:0] width;
        logic        dropped;
    } width_rec_t;

    // column model and queue of pending widths
    class width_board;
        logic [29:0] column[$];
        logic        dropped;
        width_rec_t  pending[$];
        int          mismatches;
        int          checked;

        // note one accepted sample beat
        function void note_sample(logic [29:0] s, logic lst);
            width_rec_t rec;
            if (column.size() < ihbw_pkg::MAX_SAMPLES)
                column.push_back(s);
            else
                dropped = 1'b1;
            if (lst)
            begin
                rec.width   = fd_width(column);
                rec.dropped = dropped;
                pending.push_back(rec);
                column.delete();
                dropped = 1'b0;
            end
        endfunction

        // floored median of sorted run lo..hi
        function logic [29:0] run_mid(logic [29:0] v[$], int lo, int hi);
            int m;
            logic [30:0] sum;
            m = hi - lo + 1;
            if (m % 2 == 0)
            begin
                sum = {1'b0, v[lo + m/2]} + {1'b0, v[lo + m/2 - 1]};
                return sum[30:1];
            end
            return v[lo + m/2];
        endfunction

        // freedman-diaconis width with exact integer cube root ceiling
        function logic [30:0] fd_width(logic [29:0] col[$]);
            logic [29:0] v[$];
            logic [29:0] q1, q3;
            logic [31:0] d, lo, hi, mid;
            logic [127:0] dcube, rcube;
            int n;
            v = col;
            v.sort();
            n = v.size();
            q1 = (n % 2 == 0) ? run_mid(v, 0, n/2 - 1) : run_mid(v, 0, n/2);
            q3 = run_mid(v, n/2, n - 1);
            d = 2 * ({2'b0, q3} - {2'b0, q1});
            if (d == 0)
                return 31'd1;
            dcube = 128'(d) * 128'(d) * 128'(d);
            lo = 0;
            hi = d;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                rcube = 128'(mid) * 128'(mid) * 128'(mid) * 128'(n);
                if (rcube >= dcube)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            return (lo < 1) ? 31'd1 : lo[30:0];
        endfunction

        // compare one result beat with the oldest expectation
        function void check_width(logic [30:0] w, logic ovf);
            width_rec_t rec;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: width %0d overflowed %0d", w, ovf);
                return;
            end
            rec = pending.pop_front();
            if (rec.width !== w || rec.dropped !== ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("width mismatch: expected %0d/%0d, got %0d/%0d",
                             rec.width, rec.dropped, w, ovf);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [29:0] sample;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] bin_width;
    logic        overflowed;

    width_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  beats_sent;
    int  columns_sent;

    integer_histogram_bin_width u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_width  (bin_width),
        .overflowed (overflowed)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stall plus an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_width(bin_width, overflowed);
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // send one beat, idling at random first
    task automatic send_beat(input logic [29:0] s, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_sample(s, lst);
        beats_sent++;
        if (lst)
            columns_sent++;
    endtask

    // random sample with a chosen spread style
    function automatic logic [29:0] rand_sample(int style);
        case (style)
            0: return 30'($urandom);
            1: return 30'($urandom_range(15));
            2: return 30'h3FFF_FFF0 | 30'($urandom_range(15));
            default: return 30'($urandom_range(1000000));
        endcase
    endfunction

    // send a whole column of n samples
    task automatic send_column(input int n);
        int style;
        style = $urandom_range(3);
        for (int k = 0; k < n; k++)
            send_beat(rand_sample(style), k == n - 1);
    endtask

    // wait until every pending width is out, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        board = new();
        board.dropped = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        last = 1'b0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single sample, zero spread, field extremes, widest spread
        send_beat(30'h3FFF_FFFF, 1'b1);
        send_beat(30'd0, 1'b1);
        send_beat(30'd7, 1'b0);
        send_beat(30'd7, 1'b0);
        send_beat(30'd7, 1'b1);
        send_beat(30'd0, 1'b0);
        send_beat(30'h3FFF_FFFF, 1'b1);
        send_beat(30'd0, 1'b0);
        send_beat(30'd0, 1'b0);
        send_beat(30'h3FFF_FFFF, 1'b0);
        send_beat(30'h3FFF_FFFF, 1'b1);
        send_beat(30'h2AAA_AAAA, 1'b0);
        send_beat(30'h1555_5555, 1'b0);
        send_beat(30'd3, 1'b1);
        drain();

        // full store, then overflow with dropped last beat
        for (int k = 0; k < ihbw_pkg::MAX_SAMPLES + 2; k++)
            send_beat(30'($urandom), k == ihbw_pkg::MAX_SAMPLES + 1);
        drain();

        // random columns under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 59) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 59) : 0;
            for (int c = 0; c < 15; c++)
                send_column($urandom_range(1, 6));
            drain();
        end

        // long receiver hold-off while columns keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (6000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int c = 0; c < 6; c++)
                    send_column($urandom_range(1, 5));
            end
        join
        drain();

        $display("ran %0d sample beats in %0d columns, %0d widths checked",
                 beats_sent, columns_sent, board.checked);
        $display("covered single, flat, extreme, full and overflowed columns");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
